>>> rtl/mrumtf_pkg.sv
package mrumtf_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 16;
  localparam int OP_W  = 2;
  localparam int CAP_W = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch incoming transaction
    logic compare;  // register key/value match vectors
    logic exec;     // update list, load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_flush;
    logic flush_last;
  } sts_t;

endpackage

>>> rtl/mrumtf_if.sv
interface mrumtf_in_if
  import mrumtf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;

  modport source (output valid, op, key, value, input ready);
  modport sink   (input valid, op, key, value, output ready);
endinterface

interface mrumtf_out_if
  import mrumtf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [VAL_W-1:0]  value_out;
  logic              evicted;
  logic              last;

  modport source (output valid, hit, value_out, evicted, last, input ready);
  modport sink   (input valid, hit, value_out, evicted, last, output ready);
endinterface

interface mrumtf_cfg_if
  import mrumtf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CAP_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/mrumtf_ctrl.sv
module mrumtf_ctrl
  import mrumtf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.exec = 1'b1;
          // last result of this transaction: take the next one right away
          if (!sts.is_flush || sts.flush_last) begin
            in_ready = 1'b1;
            if (in_valid) begin
              cmd.load  = 1'b1;
              state_nxt = ST_CMP;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.exec ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

endmodule

>>> rtl/mrumtf_dp.sv
module mrumtf_dp
  import mrumtf_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [OP_W-1:0]  in_op,
  input  logic [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0] in_value,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  output logic             res_hit,
  output logic [VAL_W-1:0] res_value,
  output logic             res_evicted,
  output logic             res_last
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  logic [KEY_W-1:0] key_r [DEPTH];
  logic [VAL_W-1:0] val_r [DEPTH];
  logic [KEY_W-1:0] key_nxt [DEPTH];
  logic [VAL_W-1:0] val_nxt [DEPTH];

  logic [CW-1:0]    count_r, count_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [IW-1:0]    fidx_r, fidx_nxt;

  op_t              op_r;
  logic [KEY_W-1:0] ikey_r;
  logic [VAL_W-1:0] ival_r;
  logic [DEPTH-1:0] khit_r, vhit_r;

  logic             hit_r, evicted_r, last_r;
  logic [VAL_W-1:0] value_r;
  logic             hit_nxt, evicted_nxt, last_nxt;
  logic [VAL_W-1:0] value_nxt;

  logic [IW-1:0]    kpos, vpos, tail;
  logic [XW-1:0]    eff_cap;
  logic             evict;
  logic [CW-1:0]    top;

  // effective capacity: 0 acts as 1, anything above DEPTH acts as DEPTH
  always_comb begin
    if (cap_r == '0)
      eff_cap = XW'(1);
    else if (XW'(cap_r) > XW'(DEPTH))
      eff_cap = XW'(DEPTH);
    else
      eff_cap = XW'(cap_r);
  end

  // first match from the front
  always_comb begin
    kpos = '0;
    vpos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (khit_r[i]) kpos = IW'(i);
      if (vhit_r[i]) vpos = IW'(i);
    end
  end

  assign tail  = IW'(count_r - CW'(1));
  assign evict = (XW'(count_r) >= eff_cap) && (count_r != '0);
  assign top   = evict ? (count_r - CW'(1)) : count_r;

  assign sts.is_flush   = (op_r == OP_FLUSH);
  assign sts.flush_last = (count_r == '0) || ((CW'(fidx_r) + CW'(1)) == count_r);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      key_nxt[i] = key_r[i];
      val_nxt[i] = val_r[i];
    end
    count_nxt   = count_r;
    fidx_nxt    = fidx_r;
    hit_nxt     = 1'b0;
    value_nxt   = '0;
    evicted_nxt = 1'b0;
    last_nxt    = 1'b1;
    unique case (op_r)
      OP_LOOKUP: begin
        if (|khit_r) begin
          hit_nxt   = 1'b1;
          value_nxt = val_r[kpos];
          for (int i = 1; i < DEPTH; i++) begin
            if (IW'(i) <= kpos) begin
              key_nxt[i] = key_r[i-1];
              val_nxt[i] = val_r[i-1];
            end
          end
          key_nxt[0] = key_r[kpos];
          val_nxt[0] = val_r[kpos];
        end
      end
      OP_INSERT: begin
        for (int i = 1; i < DEPTH; i++) begin
          if (CW'(i) <= top) begin
            key_nxt[i] = key_r[i-1];
            val_nxt[i] = val_r[i-1];
          end
        end
        key_nxt[0] = ikey_r;
        val_nxt[0] = ival_r;
        if (evict) begin
          value_nxt   = val_r[tail];
          evicted_nxt = 1'b1;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (|vhit_r) begin
          hit_nxt   = 1'b1;
          value_nxt = ival_r;
          count_nxt = count_r - CW'(1);
          // close the gap
          for (int j = 0; j < DEPTH - 1; j++) begin
            if (IW'(j) >= vpos) begin
              key_nxt[j] = key_r[j+1];
              val_nxt[j] = val_r[j+1];
            end
          end
        end
      end
      OP_FLUSH: begin
        if (count_r != '0) begin
          value_nxt   = val_r[fidx_r];
          evicted_nxt = 1'b1;
          last_nxt    = sts.flush_last;
          if (sts.flush_last) begin
            count_nxt = '0;
            fidx_nxt  = '0;
          end else begin
            fidx_nxt = fidx_r + IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= CAP_RESET;
      fidx_r  <= '0;
    end else begin
      if (cfg_we) cap_r <= cfg_data;
      if (cmd.exec) begin
        count_r <= count_nxt;
        fidx_r  <= fidx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_op);
      ikey_r <= in_key;
      ival_r <= in_value;
    end
    if (cmd.compare) begin
      for (int i = 0; i < DEPTH; i++) begin
        khit_r[i] <= (CW'(i) < count_r) && (key_r[i] == ikey_r);
        vhit_r[i] <= (CW'(i) < count_r) && (val_r[i] == ival_r);
      end
    end
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        key_r[i] <= key_nxt[i];
        val_r[i] <= val_nxt[i];
      end
      hit_r     <= hit_nxt;
      value_r   <= value_nxt;
      evicted_r <= evicted_nxt;
      last_r    <= last_nxt;
    end
  end

  assign res_hit     = hit_r;
  assign res_value   = value_r;
  assign res_evicted = evicted_r;
  assign res_last    = last_r;

endmodule

>>> rtl/mru_cache_move_to_front_core.sv
// Move-to-front key/value cache: up to DEPTH key/value pairs held in registers,
// slot 0 most recent. op selects lookup (hit moves the pair to the front and
// returns its value), insert (new pair at the front; at capacity the last pair
// is evicted and reported), remove by value (first match from the front is
// dropped, list compacted) or flush (every stored value reported as evicted,
// front to back, one result per cycle while the output keeps up, list emptied).
// Each input transaction yields one result, a flush of n pairs yields n (one,
// not evicted, when empty); 'last' marks the final one. Steps: register the
// parallel key/value compare, then shift the list and load the result register;
// a flush repeats the second step once per reported value. A new transaction
// is accepted in the cycle the previous one delivers its last result into the
// output register, so lookups/inserts/removes run back to back while the
// output side keeps up. The capacity register (cfg port, always ready) may be
// written only while idle; 0 acts as 1, above DEPTH acts as DEPTH. No clearing
// pass after reset: slots beyond the count never affect a result.
module mru_cache_move_to_front_core
  import mrumtf_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  mrumtf_in_if.sink    in_ch,
  mrumtf_out_if.source out_ch,
  mrumtf_cfg_if.sink   cfg_ch
);

  cmd_t cmd;
  sts_t sts;

  // config register always takes writes
  assign cfg_ch.ready = 1'b1;

  mrumtf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mrumtf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (in_ch.op),
    .in_key      (in_ch.key),
    .in_value    (in_ch.value),
    .cfg_we      (cfg_ch.valid),
    .cfg_data    (cfg_ch.data),
    .res_hit     (out_ch.hit),
    .res_value   (out_ch.value_out),
    .res_evicted (out_ch.evicted),
    .res_last    (out_ch.last)
  );

endmodule
